// ===== hdl/bigs_pkg.sv =====
// Package: types, constants and status codes for the insertion gain scanner.
`timescale 1ns / 1ps

package bigs_pkg;

   localparam int POS_BITS    = 20;
   localparam int WEIGHT_BITS = 16;
   localparam int SUM_BITS    = 26;
   localparam int BEST_BITS   = 25;
   localparam int GAIN_BITS   = 24;
   localparam int STATUS_BITS = 2;

   localparam int REQ_DATA_BITS = 56;  // 20 + 16 + 16 = 52, padded to bytes
   localparam int RSP_DATA_BITS = 48;  // 20 + 24 = 44, padded to bytes

   typedef logic [POS_BITS-1:0]           pos_type;
   typedef logic [WEIGHT_BITS-1:0]        weight_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic signed [WEIGHT_BITS:0]   diff_type;
   typedef logic [BEST_BITS-1:0]          best_type;
   typedef logic [GAIN_BITS-1:0]          gain_type;
   typedef logic [STATUS_BITS-1:0]        status_type;

   localparam sum_type  SUM_MAX  = sum_type'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
   localparam gain_type GAIN_MAX = '1;

   localparam status_type STATUS_MOVE    = 2'd0;
   localparam status_type STATUS_NO_MOVE = 2'd1;
   localparam status_type STATUS_ABSENT  = 2'd2;

   // State captured after the last element of a subset
   typedef struct packed {
      logic     mover_found;
      logic     left_seen;
      sum_type  prefix_sum;
      sum_type  min_prefix;
      pos_type  min_prefix_pos;
      pos_type  mover_pos;
      best_type best_right_gain;
      pos_type  best_right_pos;
   } snap_type;

   // Running sum plus difference, clamped to +-SUM_MAX
   function automatic sum_type sat_add(input sum_type a, input diff_type d);
      logic signed [SUM_BITS:0] s;
      s = (SUM_BITS + 1)'(a) + (SUM_BITS + 1)'(d);
      if (s > (SUM_BITS + 1)'(SUM_MAX)) begin
         return SUM_MAX;
      end else if (s < -(SUM_BITS + 1)'(SUM_MAX)) begin
         return -SUM_MAX;
      end
      return s[SUM_BITS-1:0];
   endfunction

endpackage

// ===== hdl/best_insertion_gain_scanner_core.sv =====
// Top level: scans a mover's neighborhood and reports the best reinsertion point.
//
//   channel | dir | tdata (low bit up)                     | tuser    | tlast
//   req_    | in  | position, weight_from_mover, w_to_mover | is_mover | last
//   rsp_    | out | target_position, gain                   | status   | -
//
// One request per cycle while no response is held unaccepted. A request is
// registered in the input register when accepted; the scan state and a snapshot
// of the finished scan then load from it, and the result register loads from
// the snapshot, raising rsp_tvalid for the last request of a subset. All stages
// advance together; they hold only while a response sits in the output register
// unaccepted. Synchronous reset clears valid bits and the scan state.
`timescale 1ns / 1ps

module best_insertion_gain_scanner_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // position[19:0], weight_from_mover[35:20], weight_to_mover[51:36], zero pad
   input  logic [bigs_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // is_mover[0]
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // target_position[19:0], gain[43:20], zero pad
   output logic [bigs_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // status[1:0]
   output logic [bigs_pkg::STATUS_BITS-1:0]  rsp_tuser
);
   import bigs_pkg::*;

   logic advance;

   // input register
   logic       in_vld_ff, in_vld_in;
   pos_type    in_pos_ff;
   weight_type in_wf_ff, in_wt_ff;
   logic       in_mover_ff, in_last_ff;

   // scan state
   sum_type  prefix_ff, prefix_in;
   sum_type  min_prefix_ff, min_prefix_in;
   pos_type  min_pos_ff, min_pos_in;
   logic     left_seen_ff, left_seen_in;
   logic     mover_found_ff, mover_found_in;
   pos_type  mover_pos_ff, mover_pos_in;
   sum_type  right_sum_ff, right_sum_in;
   best_type best_right_ff, best_right_in;
   pos_type  best_right_pos_ff, best_right_pos_in;

   // snapshot of the finished scan
   logic     snap_vld_ff, snap_vld_in;
   snap_type snap_ff, snap_in;

   // output register
   logic       rsp_vld_ff, rsp_vld_in;
   status_type rsp_status_ff, rsp_status_in;
   pos_type    rsp_target_ff, rsp_target_in;
   gain_type   rsp_gain_ff, rsp_gain_in;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;
   assign in_vld_in  = advance ? req_tvalid : in_vld_ff;

   // ---------------------------------------------------------------- scan
   diff_type left_diff, right_diff;
   sum_type  prefix_upd, min_prefix_upd, right_upd;
   pos_type  min_pos_upd, mover_pos_upd, best_right_pos_upd;
   logic     left_seen_upd, mover_found_upd;
   best_type best_right_upd;
   logic     step;

   assign step       = advance && in_vld_ff;
   assign left_diff  = diff_type'({1'b0, in_wf_ff}) - diff_type'({1'b0, in_wt_ff});
   assign right_diff = -left_diff;

   always_comb begin
      prefix_upd         = prefix_ff;
      min_prefix_upd     = min_prefix_ff;
      min_pos_upd        = min_pos_ff;
      left_seen_upd      = left_seen_ff;
      mover_found_upd    = mover_found_ff;
      mover_pos_upd      = mover_pos_ff;
      right_upd          = right_sum_ff;
      best_right_upd     = best_right_ff;
      best_right_pos_upd = best_right_pos_ff;
      if (!mover_found_ff) begin
         if (in_mover_ff) begin
            mover_found_upd = 1'b1;
            mover_pos_upd   = in_pos_ff;
         end else begin
            // the minimum is taken over prefixes before each left element
            if (!left_seen_ff || prefix_ff < min_prefix_ff) begin
               min_prefix_upd = prefix_ff;
               min_pos_upd    = in_pos_ff;
            end
            left_seen_upd = 1'b1;
            prefix_upd    = sat_add(prefix_ff, left_diff);
         end
      end else begin
         right_upd = sat_add(right_sum_ff, right_diff);
         if (right_upd > sum_type'({1'b0, best_right_ff})) begin
            best_right_upd     = right_upd[BEST_BITS-1:0];
            best_right_pos_upd = in_pos_ff;
         end
      end
   end

   always_comb begin
      prefix_in         = prefix_ff;
      min_prefix_in     = min_prefix_ff;
      min_pos_in        = min_pos_ff;
      left_seen_in      = left_seen_ff;
      mover_found_in    = mover_found_ff;
      mover_pos_in      = mover_pos_ff;
      right_sum_in      = right_sum_ff;
      best_right_in     = best_right_ff;
      best_right_pos_in = best_right_pos_ff;
      if (step) begin
         if (in_last_ff) begin
            prefix_in         = '0;
            min_prefix_in     = '0;
            min_pos_in        = '0;
            left_seen_in      = 1'b0;
            mover_found_in    = 1'b0;
            mover_pos_in      = '0;
            right_sum_in      = '0;
            best_right_in     = '0;
            best_right_pos_in = '0;
         end else begin
            prefix_in         = prefix_upd;
            min_prefix_in     = min_prefix_upd;
            min_pos_in        = min_pos_upd;
            left_seen_in      = left_seen_upd;
            mover_found_in    = mover_found_upd;
            mover_pos_in      = mover_pos_upd;
            right_sum_in      = right_upd;
            best_right_in     = best_right_upd;
            best_right_pos_in = best_right_pos_upd;
         end
      end
   end

   assign snap_vld_in = advance ? (in_vld_ff && in_last_ff) : snap_vld_ff;

   always_comb begin
      snap_in = snap_ff;
      if (step && in_last_ff) begin
         snap_in.mover_found     = mover_found_upd;
         snap_in.left_seen       = left_seen_upd;
         snap_in.prefix_sum      = prefix_upd;
         snap_in.min_prefix      = min_prefix_upd;
         snap_in.min_prefix_pos  = min_pos_upd;
         snap_in.mover_pos       = mover_pos_upd;
         snap_in.best_right_gain = best_right_upd;
         snap_in.best_right_pos  = best_right_pos_upd;
      end
   end

   // -------------------------------------------------------------- result
   logic signed [SUM_BITS:0] left_gain;
   logic [SUM_BITS:0]        best_gain;
   pos_type                  best_pos;

   assign left_gain = (SUM_BITS + 1)'(snap_ff.prefix_sum) - (SUM_BITS + 1)'(snap_ff.min_prefix);

   always_comb begin
      best_gain = '0;
      best_pos  = snap_ff.mover_pos;
      if (snap_ff.left_seen && left_gain > 0) begin
         best_gain = left_gain;
         best_pos  = snap_ff.min_prefix_pos;
      end
      // strict compare keeps the leftmost position on a tie
      if ((SUM_BITS + 1)'(snap_ff.best_right_gain) > best_gain) begin
         best_gain = (SUM_BITS + 1)'(snap_ff.best_right_gain);
         best_pos  = snap_ff.best_right_pos;
      end
   end

   always_comb begin
      rsp_vld_in    = rsp_vld_ff;
      rsp_status_in = rsp_status_ff;
      rsp_target_in = rsp_target_ff;
      rsp_gain_in   = rsp_gain_ff;
      if (advance) begin
         rsp_vld_in = snap_vld_ff;
         if (!snap_ff.mover_found) begin
            rsp_status_in = STATUS_ABSENT;
            rsp_target_in = '0;
            rsp_gain_in   = '0;
         end else if (best_gain != '0) begin
            rsp_status_in = STATUS_MOVE;
            rsp_target_in = best_pos;
            rsp_gain_in   = (best_gain > (SUM_BITS + 1)'(GAIN_MAX)) ?
                            GAIN_MAX : best_gain[GAIN_BITS-1:0];
         end else begin
            rsp_status_in = STATUS_NO_MOVE;
            rsp_target_in = snap_ff.mover_pos;
            rsp_gain_in   = '0;
         end
      end
   end

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff         <= 1'b0;
         snap_vld_ff       <= 1'b0;
         rsp_vld_ff        <= 1'b0;
         prefix_ff         <= '0;
         min_prefix_ff     <= '0;
         min_pos_ff        <= '0;
         left_seen_ff      <= 1'b0;
         mover_found_ff    <= 1'b0;
         mover_pos_ff      <= '0;
         right_sum_ff      <= '0;
         best_right_ff     <= '0;
         best_right_pos_ff <= '0;
      end else begin
         in_vld_ff         <= in_vld_in;
         snap_vld_ff       <= snap_vld_in;
         rsp_vld_ff        <= rsp_vld_in;
         prefix_ff         <= prefix_in;
         min_prefix_ff     <= min_prefix_in;
         min_pos_ff        <= min_pos_in;
         left_seen_ff      <= left_seen_in;
         mover_found_ff    <= mover_found_in;
         mover_pos_ff      <= mover_pos_in;
         right_sum_ff      <= right_sum_in;
         best_right_ff     <= best_right_in;
         best_right_pos_ff <= best_right_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_pos_ff   <= req_tdata[POS_BITS-1:0];
         in_wf_ff    <= req_tdata[POS_BITS +: WEIGHT_BITS];
         in_wt_ff    <= req_tdata[POS_BITS + WEIGHT_BITS +: WEIGHT_BITS];
         in_mover_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
      snap_ff       <= snap_in;
      rsp_status_ff <= rsp_status_in;
      rsp_target_ff <= rsp_target_in;
      rsp_gain_ff   <= rsp_gain_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - POS_BITS - GAIN_BITS)'(0), rsp_gain_ff, rsp_target_ff};

`ifndef SYNTHESIS
   // input side only stalls when a response is held
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow the output stall");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_MOVE || rsp_tuser == STATUS_NO_MOVE ||
                      rsp_tuser == STATUS_ABSENT))
      else $error("response carries an undefined status");

   a_move_gain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_MOVE) |-> rsp_tdata[POS_BITS +: GAIN_BITS] != '0)
      else $error("improving move reported with zero gain");

   a_no_gain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_MOVE) |-> rsp_tdata[POS_BITS +: GAIN_BITS] == '0)
      else $error("gain reported without a move");

   a_absent_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_ABSENT) |-> rsp_tdata[POS_BITS-1:0] == '0)
      else $error("missing mover reported with a target position");
`endif

endmodule
